// File: design/stoa_pkg.sv
package stoa_pkg;

	localparam int FIFO_DEPTH_DEF = 256;

	localparam logic       OP_SCAN     = 1'b0;
	localparam logic       OP_READ     = 1'b1;
	localparam logic [7:0] RELEASE_BIT = 8'h80;
	localparam logic [6:0] LSHIFT_CODE = 7'h2A;
	localparam logic [6:0] RSHIFT_CODE = 7'h36;

	typedef logic [6:0] char_t;

	typedef struct packed {
		logic  rd;
		logic  push_req;
		char_t ch;
	} dec_t;

	function automatic char_t plain_map(input logic [6:0] idx);
		char_t r;
		unique case (idx)
			7'h02: r = 7'h31;
			7'h03: r = 7'h32;
			7'h04: r = 7'h33;
			7'h05: r = 7'h34;
			7'h06: r = 7'h35;
			7'h07: r = 7'h36;
			7'h08: r = 7'h37;
			7'h09: r = 7'h38;
			7'h0A: r = 7'h39;
			7'h0B: r = 7'h30;
			7'h0C: r = 7'h2D;
			7'h0D: r = 7'h3D;
			7'h0E: r = 7'h08;
			7'h0F: r = 7'h09;
			7'h10: r = 7'h71;
			7'h11: r = 7'h77;
			7'h12: r = 7'h65;
			7'h13: r = 7'h72;
			7'h14: r = 7'h74;
			7'h15: r = 7'h79;
			7'h16: r = 7'h75;
			7'h17: r = 7'h69;
			7'h18: r = 7'h6F;
			7'h19: r = 7'h70;
			7'h1A: r = 7'h5B;
			7'h1B: r = 7'h5D;
			7'h1C: r = 7'h0A;
			7'h1E: r = 7'h61;
			7'h1F: r = 7'h73;
			7'h20: r = 7'h64;
			7'h21: r = 7'h66;
			7'h22: r = 7'h67;
			7'h23: r = 7'h68;
			7'h24: r = 7'h6A;
			7'h25: r = 7'h6B;
			7'h26: r = 7'h6C;
			7'h27: r = 7'h3B;
			7'h28: r = 7'h27;
			7'h29: r = 7'h60;
			7'h2B: r = 7'h5C;
			7'h2C: r = 7'h7A;
			7'h2D: r = 7'h78;
			7'h2E: r = 7'h63;
			7'h2F: r = 7'h76;
			7'h30: r = 7'h62;
			7'h31: r = 7'h6E;
			7'h32: r = 7'h6D;
			7'h33: r = 7'h2C;
			7'h34: r = 7'h2E;
			7'h35: r = 7'h2F;
			7'h37: r = 7'h2A;
			7'h39: r = 7'h20;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	function automatic char_t shifted_map(input logic [6:0] idx);
		char_t r;
		unique case (idx)
			7'h02: r = 7'h21;
			7'h03: r = 7'h40;
			7'h04: r = 7'h23;
			7'h05: r = 7'h24;
			7'h06: r = 7'h25;
			7'h07: r = 7'h5E;
			7'h08: r = 7'h26;
			7'h09: r = 7'h2A;
			7'h0A: r = 7'h28;
			7'h0B: r = 7'h29;
			7'h0C: r = 7'h5F;
			7'h0D: r = 7'h2B;
			7'h0E: r = 7'h08;
			7'h0F: r = 7'h09;
			7'h10: r = 7'h51;
			7'h11: r = 7'h57;
			7'h12: r = 7'h45;
			7'h13: r = 7'h52;
			7'h14: r = 7'h54;
			7'h15: r = 7'h59;
			7'h16: r = 7'h55;
			7'h17: r = 7'h49;
			7'h18: r = 7'h4F;
			7'h19: r = 7'h50;
			7'h1A: r = 7'h7B;
			7'h1B: r = 7'h7D;
			7'h1C: r = 7'h0A;
			7'h1E: r = 7'h41;
			7'h1F: r = 7'h53;
			7'h20: r = 7'h44;
			7'h21: r = 7'h46;
			7'h22: r = 7'h47;
			7'h23: r = 7'h48;
			7'h24: r = 7'h4A;
			7'h25: r = 7'h4B;
			7'h26: r = 7'h4C;
			7'h27: r = 7'h3A;
			7'h28: r = 7'h22;
			7'h29: r = 7'h7E;
			7'h2B: r = 7'h7C;
			7'h2C: r = 7'h5A;
			7'h2D: r = 7'h58;
			7'h2E: r = 7'h43;
			7'h2F: r = 7'h56;
			7'h30: r = 7'h42;
			7'h31: r = 7'h4E;
			7'h32: r = 7'h4D;
			7'h33: r = 7'h3C;
			7'h34: r = 7'h3E;
			7'h35: r = 7'h3F;
			7'h37: r = 7'h2A;
			7'h39: r = 7'h20;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

endpackage

// File: design/stoa_ram.sv
module stoa_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/stoa_decode.sv
module stoa_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          xfer,
	input  logic          op,
	input  logic [7:0]    scancode,
	output stoa_pkg::dec_t dec
);

	import stoa_pkg::*;

	logic       shift_held_q;
	logic [6:0] key;
	logic       is_shift;
	logic       is_release;
	char_t      t;

	assign key        = scancode[6:0];
	assign is_shift   = (key == LSHIFT_CODE) || (key == RSHIFT_CODE);
	assign is_release = (scancode & RELEASE_BIT) != 8'h00;
	assign t          = shift_held_q ? shifted_map(key) : plain_map(key);

	always_comb begin
		dec.rd       = (op == OP_READ);
		dec.push_req = (op == OP_SCAN) && !is_release && !is_shift && (t != 7'h00);
		dec.ch       = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_held_q <= 1'b0;
		end else if (xfer && op == OP_SCAN && is_shift) begin
			shift_held_q <= !is_release;
		end
	end

endmodule

// File: design/scancode_to_ascii_key_fifo.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_ready   | op, scancode
// output  | out_valid / out_ready | character, dropped
//
// One item per cycle sustained while the output is not stalled; a result passes the key store
// read stage, then the output register, before it is presented and can leave.
// The key store RAM is read at the read pointer in the transfer cycle; the pop data
// lands in the output register when the read stage advances.
// Reset clears pointers, shift flag and valid bits; the key store is not cleared.
// A stalled output holds the read stage; in_ready drops only when both stages are full.
module scancode_to_ascii_key_fifo #(
	parameter int FIFO_DEPTH = stoa_pkg::FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] scancode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] character,
	output logic       dropped
);

	import stoa_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	logic          xfer;
	dec_t          dec;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_nxt;
	logic [AW-1:0] rp_nxt;
	logic          empty;
	logic          full;
	logic          push;
	logic          pop;
	logic          drop;
	char_t         rdata;
	logic          valid_s1;
	logic          pop_s1;
	logic          drop_s1;
	logic          adv_s1;
	logic          out_valid_q;
	char_t         character_q;
	logic          dropped_q;

	assign adv_s1   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign xfer     = in_valid && in_ready;

	stoa_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.xfer     (xfer),
		.op       (op),
		.scancode (scancode),
		.dec      (dec)
	);

	assign wp_nxt = (wp_q == AW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_nxt = (rp_q == AW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign empty  = (rp_q == wp_q);
	assign full   = (wp_nxt == rp_q);
	assign pop    = xfer && dec.rd && !empty;
	assign push   = xfer && dec.push_req && !full;
	assign drop   = xfer && dec.push_req && full;

	stoa_ram #(
		.WIDTH ($bits(char_t)),
		.DEPTH (FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push),
		.waddr (wp_q),
		.wdata (dec.ch),
		.re    (pop),
		.raddr (rp_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_nxt;
			end
			if (pop) begin
				rp_q <= rp_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pop_s1   <= 1'b0;
			drop_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= xfer;
			pop_s1   <= pop;
			drop_s1  <= drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			character_q <= pop_s1 ? rdata : 7'h00;
			dropped_q   <= drop_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign dropped   = dropped_q;

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	a_pop_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && pop_s1 && adv_s1) |=> (out_valid_q && character != 7'h00))
		else $error("popped character is zero");

	a_drop_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && drop_s1) |-> !pop_s1)
		else $error("drop and pop on one item");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (rp_q != wp_q))
		else $error("fifo empty after push");
`endif

endmodule

// File: test/tb_scancode_to_ascii_key_fifo.sv
`timescale 1ns / 1ps

module tb_scancode_to_ascii_key_fifo;
	import stoa_pkg::*;

	class key_scoreboard;
		typedef struct {
			bit [6:0] ch;
			bit       drop;
		} key_result_t;

		bit [6:0]    held_keys[$];
		key_result_t awaited[$];
		bit          shift_on;
		int          errors;

		function new();
			shift_on = 1'b0;
			errors   = 0;
		endfunction

		// {plain, shifted} character for a make code
		function bit [13:0] key_pair(bit [6:0] idx);
			bit [13:0] p;
			case (idx)
				7'h02: p = {7'h31, 7'h21};
				7'h03: p = {7'h32, 7'h40};
				7'h04: p = {7'h33, 7'h23};
				7'h05: p = {7'h34, 7'h24};
				7'h06: p = {7'h35, 7'h25};
				7'h07: p = {7'h36, 7'h5E};
				7'h08: p = {7'h37, 7'h26};
				7'h09: p = {7'h38, 7'h2A};
				7'h0A: p = {7'h39, 7'h28};
				7'h0B: p = {7'h30, 7'h29};
				7'h0C: p = {7'h2D, 7'h5F};
				7'h0D: p = {7'h3D, 7'h2B};
				7'h0E: p = {7'h08, 7'h08};
				7'h0F: p = {7'h09, 7'h09};
				7'h10: p = {7'h71, 7'h51};
				7'h11: p = {7'h77, 7'h57};
				7'h12: p = {7'h65, 7'h45};
				7'h13: p = {7'h72, 7'h52};
				7'h14: p = {7'h74, 7'h54};
				7'h15: p = {7'h79, 7'h59};
				7'h16: p = {7'h75, 7'h55};
				7'h17: p = {7'h69, 7'h49};
				7'h18: p = {7'h6F, 7'h4F};
				7'h19: p = {7'h70, 7'h50};
				7'h1A: p = {7'h5B, 7'h7B};
				7'h1B: p = {7'h5D, 7'h7D};
				7'h1C: p = {7'h0A, 7'h0A};
				7'h1E: p = {7'h61, 7'h41};
				7'h1F: p = {7'h73, 7'h53};
				7'h20: p = {7'h64, 7'h44};
				7'h21: p = {7'h66, 7'h46};
				7'h22: p = {7'h67, 7'h47};
				7'h23: p = {7'h68, 7'h48};
				7'h24: p = {7'h6A, 7'h4A};
				7'h25: p = {7'h6B, 7'h4B};
				7'h26: p = {7'h6C, 7'h4C};
				7'h27: p = {7'h3B, 7'h3A};
				7'h28: p = {7'h27, 7'h22};
				7'h29: p = {7'h60, 7'h7E};
				7'h2B: p = {7'h5C, 7'h7C};
				7'h2C: p = {7'h7A, 7'h5A};
				7'h2D: p = {7'h78, 7'h58};
				7'h2E: p = {7'h63, 7'h43};
				7'h2F: p = {7'h76, 7'h56};
				7'h30: p = {7'h62, 7'h42};
				7'h31: p = {7'h6E, 7'h4E};
				7'h32: p = {7'h6D, 7'h4D};
				7'h33: p = {7'h2C, 7'h3C};
				7'h34: p = {7'h2E, 7'h3E};
				7'h35: p = {7'h2F, 7'h3F};
				7'h37: p = {7'h2A, 7'h2A};
				7'h39: p = {7'h20, 7'h20};
				default: p = 14'h0000;
			endcase
			return p;
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			errors++;
		endtask

		task note_input(bit is_read, bit [7:0] code);
			key_result_t r;
			bit [13:0]   pair;
			bit [6:0]    ch;
			r.ch   = 7'h00;
			r.drop = 1'b0;
			if (is_read == OP_READ) begin
				if (held_keys.size() != 0)
					r.ch = held_keys.pop_front();
			end else if ((code & RELEASE_BIT) != 0) begin
				if (code[6:0] == LSHIFT_CODE || code[6:0] == RSHIFT_CODE)
					shift_on = 1'b0;
			end else if (code[6:0] == LSHIFT_CODE || code[6:0] == RSHIFT_CODE) begin
				shift_on = 1'b1;
			end else begin
				pair = key_pair(code[6:0]);
				ch   = shift_on ? pair[6:0] : pair[13:7];
				if (ch != 7'h00) begin
					if (held_keys.size() == FIFO_DEPTH_DEF - 1)
						r.drop = 1'b1;
					else
						held_keys.push_back(ch);
				end
			end
			awaited.push_back(r);
		endtask

		task check_result(logic [6:0] ch, logic drop);
			key_result_t e;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result character=%h dropped=%b", ch, drop));
				return;
			end
			e = awaited.pop_front();
			if (ch !== e.ch)
				report($sformatf("character %h, want %h", ch, e.ch));
			if (drop !== e.drop)
				report($sformatf("dropped %b, want %b", drop, e.drop));
		endtask

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic       op        = OP_SCAN;
	logic [7:0] scancode  = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] character;
	logic       dropped;

	key_scoreboard book;
	int idle_pct   = 0;
	int stall_pct  = 0;
	int sent_count = 0;

	scancode_to_ascii_key_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.scancode  (scancode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.dropped   (dropped)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				book.note_input(op, scancode);
			if (out_valid && out_ready)
				book.check_result(character, dropped);
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(logic o, logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		scancode <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_key();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h39));
		while (book.key_pair(c[6:0]) == 14'h0000);
		return c;
	endfunction

	task automatic type_burst(int n);
		logic       use_shift;
		logic [7:0] sc;
		logic [7:0] k;
		use_shift = 1'($urandom_range(1));
		sc        = $urandom_range(1) ? {1'b0, LSHIFT_CODE} : {1'b0, RSHIFT_CODE};
		if (use_shift)
			send_item(OP_SCAN, sc);
		repeat (n) begin
			k = pick_key();
			send_item(OP_SCAN, k);
			if ($urandom_range(1))
				send_item(OP_SCAN, k | RELEASE_BIT);
			if ($urandom_range(2) == 0)
				send_item(OP_READ, 8'($urandom));
		end
		if (use_shift)
			send_item(OP_SCAN, sc | RELEASE_BIT);
	endtask

	task automatic run_mixed(int n);
		int start;
		int r;
		start = sent_count;
		while (sent_count - start < n) begin
			r = $urandom_range(9);
			if (r < 5) begin
				type_burst($urandom_range(1, 6));
			end else if (r < 8) begin
				repeat ($urandom_range(1, 5))
					send_item(OP_READ, 8'($urandom));
			end else begin
				send_item(1'($urandom_range(1)), 8'($urandom));
			end
		end
	endtask

	initial begin
		int waited;
		book = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(OP_READ, 8'h00);
		send_item(OP_READ, 8'hFF);
		send_item(OP_SCAN, 8'h00);
		send_item(OP_SCAN, 8'h7F);
		send_item(OP_SCAN, 8'h01);
		send_item(OP_SCAN, 8'h1E);
		send_item(OP_SCAN, 8'h39);
		send_item(OP_SCAN, 8'h02);
		send_item(OP_SCAN, {1'b0, LSHIFT_CODE});
		send_item(OP_SCAN, 8'h1E);
		send_item(OP_SCAN, 8'h02);
		send_item(OP_SCAN, {1'b0, LSHIFT_CODE} | RELEASE_BIT);
		send_item(OP_SCAN, {1'b0, RSHIFT_CODE});
		send_item(OP_SCAN, 8'h29);
		send_item(OP_SCAN, 8'h9E);
		send_item(OP_SCAN, {1'b0, RSHIFT_CODE} | RELEASE_BIT);
		send_item(OP_SCAN, 8'h80);
		send_item(OP_SCAN, 8'hFF);
		send_item(OP_SCAN, 8'h29);
		repeat (8)
			send_item(OP_READ, 8'($urandom));

		// fill past full, then drain past empty
		repeat (300)
			send_item(OP_SCAN, pick_key());
		repeat (260)
			send_item(OP_READ, 8'($urandom));
		run_mixed(60);

		idle_pct  = 73;
		stall_pct = 0;
		run_mixed(100);
		idle_pct  = 0;
		stall_pct = 73;
		run_mixed(100);
		idle_pct  = 17;
		stall_pct = 17;
		run_mixed(100);
		in_valid <= 1'b0;

		waited = 0;
		while (book.pending() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10)
			@(posedge clk);
		if (book.pending() != 0)
			book.report($sformatf("%0d results never arrived", book.pending()));
		if (book.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
